// File: rtl/core/ctks_pkg.sv
// Package with shared constants, types and key tables of the keystroke sequencer.
`default_nettype none
package ctks_pkg;

  localparam int CODE_BITS = 21;
  localparam int NDIG      = (CODE_BITS + 3) / 4;
  localparam int CW        = 4 * NDIG;
  localparam int ND_W      = $clog2(NDIG + 1);
  localparam int IDX_W     = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int STEP_W    = $clog2(8 + 2 * NDIG);

  localparam logic [7:0] K_ENTER = 8'd28;
  localparam logic [7:0] K_BKSP  = 8'd14;
  localparam logic [7:0] K_TAB   = 8'd15;
  localparam logic [7:0] K_SPACE = 8'd57;
  localparam logic [7:0] K_CTRL  = 8'd29;
  localparam logic [7:0] K_SHIFT = 8'd42;
  localparam logic [7:0] K_U     = 8'd22;

  localparam logic EV_KEYCODE = 1'b0;
  localparam logic EV_KEYSYM  = 1'b1;

  typedef enum logic [1:0] {
    CLS_TAP,
    CLS_SYM,
    CLS_UNI
  } cls_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } sts_t;

  function automatic logic [7:0] hex_key(input logic [3:0] nib);
    logic [7:0] k;
    case (nib)
      4'h0: k = 8'd11;
      4'h1: k = 8'd2;
      4'h2: k = 8'd3;
      4'h3: k = 8'd4;
      4'h4: k = 8'd5;
      4'h5: k = 8'd6;
      4'h6: k = 8'd7;
      4'h7: k = 8'd8;
      4'h8: k = 8'd9;
      4'h9: k = 8'd10;
      4'ha: k = 8'd30;
      4'hb: k = 8'd48;
      4'hc: k = 8'd46;
      4'hd: k = 8'd32;
      4'he: k = 8'd18;
      4'hf: k = 8'd33;
      default: k = 8'd11;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ctks_ctrl.sv
// Controller state machine and session-ready register of the keystroke sequencer.
`default_nettype none
module ctks_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_session_ready,
  input  wire ctks_pkg::sts_t sts,
  output ctks_pkg::cmd_t     cmd
);
  import ctks_pkg::*;

  state_t state_r, state_nxt;
  logic   session_ready_r, session_ready_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      session_ready_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      session_ready_r <= session_ready_nxt;
    end
  end

  always_comb begin
    session_ready_nxt = session_ready_r;
    if (cfg_valid && cfg_ready) begin
      session_ready_nxt = cfg_session_ready;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && session_ready_r) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.out_free && sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready = 1'b1;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && session_ready_r;
      end
      ST_RUN: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/ctks_dp.sv
// Datapath: item decode, event step counter, event generation and output register.
`default_nettype none
module ctks_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [ctks_pkg::CODE_BITS-1:0] in_char_code,
  input  wire ctks_pkg::cmd_t           cmd,
  output ctks_pkg::sts_t                sts,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_event_kind,
  output logic [7:0]                    out_key_value,
  output logic                          out_pressed,
  output logic                          out_last_event
);
  import ctks_pkg::*;

  logic [CW-1:0]     code_r;
  cls_t              cls_r;
  logic [7:0]        key_r;
  logic [ND_W-1:0]   nd_r;
  logic [STEP_W-1:0] step_r, last_step_r;

  logic              out_valid_r, out_valid_nxt;
  logic              kind_r;
  logic [7:0]        val_r;
  logic              press_r;
  logic              lastev_r;

  logic [CW-1:0]     code_in;
  cls_t              cls_in;
  logic [7:0]        key_in;
  logic [ND_W-1:0]   nd_in;

  logic [3:0]        nib [NDIG];
  logic              ev_kind;
  logic [7:0]        ev_val;
  logic              ev_press;
  logic [STEP_W-1:0] space_step, dig_pos;

  assign code_in = CW'(in_char_code);

  always_comb begin
    nd_in = ND_W'(1);
    for (int i = 0; i < NDIG; i++) begin
      if (code_in[4*i +: 4] != 4'h0) begin
        nd_in = ND_W'(i + 1);
      end
    end
  end

  always_comb begin
    cls_in = CLS_UNI;
    key_in = K_SPACE;
    if (code_in == CW'('h0D) || code_in == CW'('h0A)) begin
      cls_in = CLS_TAP;
      key_in = K_ENTER;
    end else if (code_in == CW'('h08)) begin
      cls_in = CLS_TAP;
      key_in = K_BKSP;
    end else if (code_in == CW'('h09)) begin
      cls_in = CLS_TAP;
      key_in = K_TAB;
    end else if (code_in == CW'('h20)) begin
      cls_in = CLS_TAP;
      key_in = K_SPACE;
    end else if (code_in >= CW'('h21) && code_in <= CW'('h7E)) begin
      cls_in = CLS_SYM;
      key_in = code_in[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r <= code_in;
      cls_r  <= cls_in;
      key_r  <= key_in;
      nd_r   <= nd_in;
      step_r <= '0;
      if (cls_in == CLS_UNI) begin
        last_step_r <= STEP_W'(7) + (STEP_W'(nd_in) << 1);
      end else begin
        last_step_r <= STEP_W'(1);
      end
    end else if (cmd.emit) begin
      step_r <= step_r + STEP_W'(1);
    end
  end

  for (genvar g = 0; g < NDIG; g++) begin : g_nib
    assign nib[g] = code_r[4*g +: 4];
  end

  assign space_step = STEP_W'(6) + (STEP_W'(nd_r) << 1);
  assign dig_pos    = STEP_W'(nd_r) - STEP_W'(1) - ((step_r - STEP_W'(6)) >> 1);

  always_comb begin
    ev_kind  = EV_KEYCODE;
    ev_val   = key_r;
    ev_press = ~step_r[0];
    case (cls_r)
      CLS_TAP: begin
        ev_val = key_r;
      end
      CLS_SYM: begin
        ev_kind = EV_KEYSYM;
      end
      CLS_UNI: begin
        if (step_r < STEP_W'(6)) begin
          case (step_r[2:0])
            3'd0: begin ev_val = K_CTRL;  ev_press = 1'b1; end
            3'd1: begin ev_val = K_SHIFT; ev_press = 1'b1; end
            3'd2: begin ev_val = K_U;     ev_press = 1'b1; end
            3'd3: begin ev_val = K_U;     ev_press = 1'b0; end
            3'd4: begin ev_val = K_SHIFT; ev_press = 1'b0; end
            default: begin ev_val = K_CTRL; ev_press = 1'b0; end
          endcase
        end else if (step_r >= space_step) begin
          ev_val = K_SPACE;
        end else begin
          ev_val = hex_key(nib[dig_pos[IDX_W-1:0]]);
        end
      end
      default: begin
        ev_val = key_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r   <= ev_kind;
      val_r    <= ev_val;
      press_r  <= ev_press;
      lastev_r <= (step_r == last_step_r);
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.last       = (step_r == last_step_r);
  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_key_value  = val_r;
  assign out_pressed    = press_r;
  assign out_last_event = lastev_r;

endmodule
`default_nettype wire

// File: rtl/core/char_to_keystroke_sequencer_unit.sv
// Top level of the character-to-keystroke sequencer.
// The input channel (in_valid/in_ready/in_char_code) takes one code point per word.
// The result channel (out_valid/out_ready and out_* fields) gives one key event
// per word; out_last_event marks the final event of a character's run.
// The configuration channel (cfg_valid/cfg_ready/cfg_session_ready) writes the
// session-ready bit; cfg_ready is always high. While that bit is low, accepted
// words are dropped and produce no events.
// A character is taken and then produces one event per cycle while the output
// register is free: two events for keycode taps and printable keysyms, and 8 + 2*d
// events for the Ctrl+Shift+U entry, where d is the number of hex digits (at most 6,
// so at most 20 events). After the accept the controller enters its run state and
// loads each event into the output register; the event counter in the datapath
// walks the run one step per cycle while that register is free, and in_ready stays
// low until the last event has been loaded into the output register.
// The output register decouples the sides: a new character is accepted while
// the last event of the previous one still waits. When the receiver stalls,
// the sequence pauses and the held word stays unchanged.
// Reset clears the state machine, the output valid and the session-ready bit.
`default_nettype none
module char_to_keystroke_sequencer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ctks_pkg::CODE_BITS-1:0] in_char_code,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_event_kind,
  output logic [7:0]                          out_key_value,
  output logic                                out_pressed,
  output logic                                out_last_event,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_session_ready
);
  import ctks_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ctks_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_session_ready (cfg_session_ready),
    .sts               (sts),
    .cmd               (cmd)
  );

  ctks_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char_code   (in_char_code),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_key_value  (out_key_value),
    .out_pressed    (out_pressed),
    .out_last_event (out_last_event)
  );

endmodule
`default_nettype wire

// File: rtl/core/ctks_checker.sv
// Port-level checker of the keystroke sequencer and its bind to the top level.
`default_nettype none
module ctks_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_event_kind,
  input wire logic [7:0] out_key_value,
  input wire logic       out_pressed,
  input wire logic       out_last_event
);
  import ctks_pkg::*;

  // A held result word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_value) &&
      $stable(out_pressed) && $stable(out_event_kind) && $stable(out_last_event))
    else $error("result word changed while stalled");

  // No new character is taken while a run is still being produced.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_event |-> !in_ready)
    else $error("input accepted in the middle of a run");

  // Keysym events carry printable codes only.
  a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_KEYSYM |->
      out_key_value >= 8'h21 && out_key_value <= 8'h7E)
    else $error("keysym value out of printable range");

  // A press never ends a run.
  a_press_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressed |-> !out_last_event)
    else $error("run ended on a key press");

endmodule

bind char_to_keystroke_sequencer_unit ctks_checker u_ctks_checker (.*);
`default_nettype wire

// File: test/char_to_keystroke_sequencer_unit_tb.sv
// Self-checking testbench of the character-to-keystroke sequencer, with a scoreboard class.
`timescale 1ns / 100ps
module char_to_keystroke_sequencer_unit_tb;
  import ctks_pkg::*;

  localparam int SETTLE_CYCLES  = 30;
  localparam int QUIET_LIMIT    = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_CHARS   = 250;
  localparam int DROPPED_CHARS  = 20;

  typedef struct packed {
    logic       kind;
    logic [7:0] key;
    logic       pressed;
    logic       last;
  } key_event_t;

  class keystroke_scoreboard;
    key_event_t expected_q[$];
    bit         session_on;
    int         errors;

    function new();
      session_on = 1'b0;
      errors     = 0;
    endfunction

    function void set_session(bit on);
      session_on = on;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] digit_keycode(logic [3:0] nib);
      case (nib)
        4'h0: return 8'd11;
        4'ha: return 8'd30;
        4'hb: return 8'd48;
        4'hc: return 8'd46;
        4'hd: return 8'd32;
        4'he: return 8'd18;
        4'hf: return 8'd33;
        default: return 8'd1 + 8'(nib);
      endcase
    endfunction

    function void push_key(logic kind, logic [7:0] key, logic pressed);
      key_event_t ev;
      ev.kind    = kind;
      ev.key     = key;
      ev.pressed = pressed;
      ev.last    = 1'b0;
      expected_q.push_back(ev);
    endfunction

    function void push_tap(logic [7:0] key);
      push_key(EV_KEYCODE, key, 1'b1);
      push_key(EV_KEYCODE, key, 1'b0);
    endfunction

    // Builds the key events that one accepted character must produce.
    function void note_char(logic [CODE_BITS-1:0] char_code);
      int unsigned code;
      int          digits;
      if (!session_on) return;
      code = 32'(char_code);
      if (code == 32'h0D || code == 32'h0A) begin
        push_tap(K_ENTER);
      end else if (code == 32'h08) begin
        push_tap(K_BKSP);
      end else if (code == 32'h09) begin
        push_tap(K_TAB);
      end else if (code == 32'h20) begin
        push_tap(K_SPACE);
      end else if (code >= 32'h21 && code <= 32'h7E) begin
        push_key(EV_KEYSYM, code[7:0], 1'b1);
        push_key(EV_KEYSYM, code[7:0], 1'b0);
      end else begin
        digits = 1;
        while (digits < 8 && (code >> (4 * digits)) != 0) digits++;
        push_key(EV_KEYCODE, K_CTRL, 1'b1);
        push_key(EV_KEYCODE, K_SHIFT, 1'b1);
        push_tap(K_U);
        push_key(EV_KEYCODE, K_SHIFT, 1'b0);
        push_key(EV_KEYCODE, K_CTRL, 1'b0);
        for (int i = digits - 1; i >= 0; i--) begin
          push_tap(digit_keycode(4'((code >> (4 * i)) & 32'hF)));
        end
        push_tap(K_SPACE);
      end
      expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_event(key_event_t got);
      key_event_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected key event: event_kind %0d key_value %0d pressed %0d last_event %0d",
               got.kind, got.key, got.pressed, got.last);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.kind !== exp.kind) begin
        $error("event_kind: expected %0d, got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.key !== exp.key) begin
        $error("key_value: expected %0d, got %0d", exp.key, got.key);
        errors++;
      end
      if (got.pressed !== exp.pressed) begin
        $error("pressed: expected %0d, got %0d", exp.pressed, got.pressed);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_event: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CODE_BITS-1:0] in_char_code;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_event_kind;
  logic [7:0]           out_key_value;
  logic                 out_pressed;
  logic                 out_last_event;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_session_ready;

  keystroke_scoreboard sb = new();

  int unsigned tx_stretch = 0;
  bit          tx_idle_on = 1'b0;
  int unsigned events_taken = 0;
  int unsigned hold_at = 32'hFFFF_FFFF;

  char_to_keystroke_sequencer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_key_value     (out_key_value),
    .out_pressed       (out_pressed),
    .out_last_event    (out_last_event),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_session_ready (cfg_session_ready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_event(key_event_t'({out_event_kind, out_key_value, out_pressed,
                                     out_last_event}));
      end
      if (in_valid && in_ready) sb.note_char(in_char_code);
      if (cfg_valid && cfg_ready) sb.set_session(cfg_session_ready);
    end
  end

  function automatic logic [CODE_BITS-1:0] rand_char();
    logic [CODE_BITS-1:0] specials [5];
    specials = '{21'h0D, 21'h0A, 21'h08, 21'h09, 21'h20};
    case ($urandom_range(0, 9))
      0, 1:    return specials[$urandom_range(0, 4)];
      2, 3, 4: return CODE_BITS'($urandom_range(8'h21, 8'h7E));
      5:       return CODE_BITS'($urandom_range(0, 8'hFF));
      6:       return CODE_BITS'($urandom_range(0, 16'hFFFF));
      7:       return CODE_BITS'($urandom_range(0, 21'h10FFFF));
      default: return CODE_BITS'($urandom());
    endcase
  endfunction

  task automatic send_char(input logic [CODE_BITS-1:0] code);
    int gap;
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(8, 40);
      tx_idle_on = ($urandom_range(0, 2) != 0);
    end
    tx_stretch--;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_session(input bit on);
    drain();
    cfg_valid         <= 1'b1;
    cfg_session_ready <= on;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls in stretches, plus one long hold-off to back up the input.
  initial begin : result_sink
    int          wait_cycles;
    int unsigned rx_stretch;
    bit          rx_idle_on;
    bit          hold_done;
    rx_stretch = 0;
    rx_idle_on = 1'b0;
    hold_done  = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && events_taken >= hold_at) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (rx_stretch == 0) begin
          rx_stretch = $urandom_range(8, 40);
          rx_idle_on = ($urandom_range(0, 2) != 0);
        end
        rx_stretch--;
        wait_cycles = rx_idle_on ? $urandom_range(0, 12) : 0;
        if (wait_cycles > 0) begin
          out_ready <= 1'b0;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      events_taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("char_to_keystroke_sequencer_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [CODE_BITS-1:0] directed [$];
    directed = '{21'h0D, 21'h0A, 21'h08, 21'h09, 21'h20, 21'h21, 21'h7E, 21'h41,
                 21'h00, 21'h07, 21'h0F, 21'h10, 21'h1F, 21'h7F, 21'h80, 21'hFF,
                 21'hFFFF, 21'hABCDE, 21'h100000, 21'h10FFFF, 21'h110000,
                 21'h1FFFFF, 21'h154321};
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_char_code      <= '0;
    cfg_valid         <= 1'b0;
    cfg_session_ready <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The session comes out of reset not ready, so these words must vanish.
    repeat (4) send_char(rand_char());
    write_session(1'b1);
    foreach (directed[i]) send_char(directed[i]);
    write_session(1'b0);
    repeat (DROPPED_CHARS) send_char(rand_char());
    write_session(1'b1);
    hold_at = events_taken + 150;
    repeat (RANDOM_CHARS) send_char(rand_char());
    write_session(1'b0);
    repeat (4) send_char(rand_char());
    write_session(1'b1);
    repeat (6) send_char(rand_char());
    drain();

    if (sb.errors == 0) begin
      $display("char_to_keystroke_sequencer_unit regression: pass");
    end else begin
      $display("char_to_keystroke_sequencer_unit regression: fail");
    end
    $finish;
  end
endmodule
